>>> rtl/gcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared widths, register codes, reset values and types of the glyph column
// rasterizer.
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int COORD_BITS  = 11;
  localparam int DIM_BITS    = 12;
  localparam int COLOR_BITS  = 16;
  localparam int HEIGHT_BITS = 6;
  localparam int GLYPH_BITS  = 8;
  localparam int IDX_BITS    = $clog2(GLYPH_BITS);
  localparam int CMP_BITS    = (COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS;

  localparam int IN_FIELD_BITS  = 2 * COORD_BITS + HEIGHT_BITS + 1 + COLOR_BITS + GLYPH_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int IN_X_LSB     = 0;
  localparam int IN_Y_LSB     = IN_X_LSB + COORD_BITS;
  localparam int IN_H_LSB     = IN_Y_LSB + COORD_BITS;
  localparam int IN_MODE_LSB  = IN_H_LSB + HEIGHT_BITS;
  localparam int IN_FG_LSB    = IN_MODE_LSB + 1;
  localparam int IN_GLYPH_LSB = IN_FG_LSB + COLOR_BITS;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam logic [DIM_BITS-1:0]   WIDTH_RST  = DIM_BITS'(800);
  localparam logic [DIM_BITS-1:0]   HEIGHT_RST = DIM_BITS'(480);
  localparam logic [COLOR_BITS-1:0] BG_RST     = {COLOR_BITS{1'b1}};

  localparam logic [HEIGHT_BITS-1:0] FONT_H12 = HEIGHT_BITS'(12);
  localparam logic [HEIGHT_BITS-1:0] FONT_H16 = HEIGHT_BITS'(16);
  localparam logic [HEIGHT_BITS-1:0] FONT_H24 = HEIGHT_BITS'(24);
  localparam logic [HEIGHT_BITS-1:0] FONT_H32 = HEIGHT_BITS'(32);

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_BG_COLOR      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_BITS-1:0]   width;
    logic [DIM_BITS-1:0]   height;
    logic [COLOR_BITS-1:0] bg;
  } gcr_cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [GLYPH_BITS-1:0] mask;
    logic [GLYPH_BITS-1:0] glyph;
    logic [COLOR_BITS-1:0] fg;
  } gcr_entry_t;

  function automatic logic height_supported(input logic [HEIGHT_BITS-1:0] h);
    return (h == FONT_H12) || (h == FONT_H16) || (h == FONT_H24) || (h == FONT_H32);
  endfunction

endpackage

>>> rtl/gcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_front
// Accepts glyph words, tracks the character position and works out which
// bits of each word produce a pixel write.
// ----------------------------------------------------------------------------
module gcr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_first_i,
  input  logic [gcr_pkg::IN_DATA_BITS-1:0]  in_data_i,
  output logic                              in_ready_o,
  input  gcr_pkg::gcr_cfg_t                 cfg_i,
  input  logic                              fifo_full_i,
  output logic                              push_o,
  output gcr_pkg::gcr_entry_t               entry_o
);

  localparam int CB = gcr_pkg::COORD_BITS;
  localparam int GB = gcr_pkg::GLYPH_BITS;

  logic [CB-1:0]                      col_q, col_d, row_q, row_d, top_q, top_d;
  logic [gcr_pkg::HEIGHT_BITS-1:0]    h_q, h_d;
  logic                               mode_q, mode_d, active_q, active_d;
  logic [gcr_pkg::COLOR_BITS-1:0]     fg_q, fg_d;

  logic [CB-1:0]                      in_x, in_y;
  logic [gcr_pkg::HEIGHT_BITS-1:0]    in_h;
  logic                               in_mode;
  logic [gcr_pkg::COLOR_BITS-1:0]     in_fg;
  logic [GB-1:0]                      in_glyph;

  logic [CB-1:0]                      cur_col, cur_row, cur_top;
  logic [gcr_pkg::HEIGHT_BITS-1:0]    cur_h;
  logic                               cur_mode, cur_active;
  logic [gcr_pkg::COLOR_BITS-1:0]     cur_fg;

  logic [GB-1:0]                      edge_v, wrap_v, mask;
  logic                               accept, alive, found, stop_edge;
  logic [CB:0]                        col_nxt;
  logic                               col_edge;

  assign in_x     = in_data_i[gcr_pkg::IN_X_LSB +: CB];
  assign in_y     = in_data_i[gcr_pkg::IN_Y_LSB +: CB];
  assign in_h     = in_data_i[gcr_pkg::IN_H_LSB +: gcr_pkg::HEIGHT_BITS];
  assign in_mode  = in_data_i[gcr_pkg::IN_MODE_LSB];
  assign in_fg    = in_data_i[gcr_pkg::IN_FG_LSB +: gcr_pkg::COLOR_BITS];
  assign in_glyph = in_data_i[gcr_pkg::IN_GLYPH_LSB +: GB];

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;

  always_comb begin
    cur_col    = in_first_i ? in_x : col_q;
    cur_row    = in_first_i ? in_y : row_q;
    cur_top    = in_first_i ? in_y : top_q;
    cur_h      = in_first_i ? in_h : h_q;
    cur_mode   = in_first_i ? in_mode : mode_q;
    cur_fg     = in_first_i ? in_fg : fg_q;
    cur_active = in_first_i ? gcr_pkg::height_supported(in_h) : active_q;
  end

  always_comb begin
    logic [CB-1:0] ri;
    logic [CB:0]   nxt;
    edge_v = '0;
    wrap_v = '0;
    for (int i = 0; i < GB; i++) begin
      ri        = cur_row + CB'(i);
      nxt       = {1'b0, ri} + (CB + 1)'(1);
      edge_v[i] = gcr_pkg::CMP_BITS'(nxt) >= gcr_pkg::CMP_BITS'(cfg_i.height);
      wrap_v[i] = (nxt[CB-1:0] - cur_top) == CB'(cur_h);
    end
  end

  always_comb begin
    alive     = 1'b1;
    found     = 1'b0;
    stop_edge = 1'b0;
    mask      = '0;
    for (int i = 0; i < GB; i++) begin
      if (alive) begin
        mask[i] = in_glyph[GB-1-i] | cur_mode;
        if (edge_v[i] || wrap_v[i]) begin
          found     = 1'b1;
          stop_edge = edge_v[i];
          alive     = 1'b0;
        end
      end
    end
  end

  assign col_nxt  = {1'b0, cur_col} + (CB + 1)'(1);
  assign col_edge = gcr_pkg::CMP_BITS'(col_nxt) >= gcr_pkg::CMP_BITS'(cfg_i.width);

  always_comb begin
    col_d    = cur_col;
    row_d    = cur_row;
    top_d    = cur_top;
    h_d      = cur_h;
    mode_d   = cur_mode;
    fg_d     = cur_fg;
    active_d = cur_active;
    if (cur_active) begin
      if (!found) begin
        row_d = cur_row + CB'(GB);
      end else if (stop_edge) begin
        active_d = 1'b0;
      end else begin
        row_d = cur_top;
        if (col_edge) begin
          active_d = 1'b0;
        end else begin
          col_d = col_nxt[CB-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      top_q    <= '0;
      h_q      <= '0;
      mode_q   <= 1'b0;
      fg_q     <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      col_q    <= col_d;
      row_q    <= row_d;
      top_q    <= top_d;
      h_q      <= h_d;
      mode_q   <= mode_d;
      fg_q     <= fg_d;
      active_q <= active_d;
    end
  end

  assign push_o        = accept && cur_active && (mask != '0);
  assign entry_o.col   = cur_col;
  assign entry_o.row   = cur_row;
  assign entry_o.mask  = mask;
  assign entry_o.glyph = in_glyph;
  assign entry_o.fg    = cur_fg;

endmodule

>>> rtl/gcr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_fifo
// Short register queue of classified glyph words between front and back.
// ----------------------------------------------------------------------------
module gcr_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gcr_pkg::gcr_entry_t  entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output gcr_pkg::gcr_entry_t  entry_o
);

  localparam int PB = gcr_pkg::FIFO_PTR_BITS;
  localparam int NB = gcr_pkg::FIFO_CNT_BITS;

  gcr_pkg::gcr_entry_t  mem_q [gcr_pkg::FIFO_DEPTH];
  logic [PB-1:0]        wr_ptr_q, rd_ptr_q;
  logic [NB-1:0]        count_q;
  logic                 do_push, do_pop;

  assign full_o  = count_q == NB'(gcr_pkg::FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PB'(gcr_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PB'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PB'(gcr_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PB'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + NB'(1);
        2'b01:   count_q <= count_q - NB'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NB'(gcr_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + NB'(1))
    else $error("queue count did not grow on push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers differ while empty");

endmodule

>>> rtl/gcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_back
// Walks the write mask of each queued glyph word and issues one pixel write
// per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module gcr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               fifo_valid_i,
  input  gcr_pkg::gcr_entry_t                fifo_entry_i,
  output logic                               pop_o,
  input  gcr_pkg::gcr_cfg_t                  cfg_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [gcr_pkg::OUT_DATA_BITS-1:0]  out_data_o,
  output logic                               out_last_o
);

  localparam int CB = gcr_pkg::COORD_BITS;
  localparam int GB = gcr_pkg::GLYPH_BITS;
  localparam int IB = gcr_pkg::IDX_BITS;

  gcr_pkg::gcr_entry_t             cur_q, cur_d;
  logic [GB-1:0]                   cur_mask_q, cur_mask_d;
  logic [IB-1:0]                   idx;
  logic [GB-1:0]                   bit_sel, rest, rest_mask;
  logic                            can_emit, fire, load;

  logic                            out_valid_q, out_valid_d;
  logic [CB-1:0]                   out_x_q, out_y_q;
  logic [gcr_pkg::COLOR_BITS-1:0]  out_color_q;
  logic                            out_last_q;

  always_comb begin
    idx = '0;
    for (int i = GB - 1; i >= 0; i--) begin
      if (cur_mask_q[i]) begin
        idx = IB'(i);
      end
    end
  end

  assign bit_sel   = GB'(1) << idx;
  assign rest      = cur_mask_q & ~bit_sel;
  assign can_emit  = !out_valid_q || out_ready_i;
  assign fire      = can_emit && (cur_mask_q != '0);
  assign rest_mask = fire ? rest : cur_mask_q;
  assign load      = (rest_mask == '0) && fifo_valid_i;
  assign pop_o     = load;

  assign cur_d       = load ? fifo_entry_i : cur_q;
  assign cur_mask_d  = load ? fifo_entry_i.mask : rest_mask;
  assign out_valid_d = can_emit ? fire : out_valid_q;

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (fire) begin
      out_x_q     <= cur_q.col;
      out_y_q     <= cur_q.row + CB'(idx);
      out_color_q <= cur_q.glyph[IB'(GB - 1) - idx] ? cur_q.fg : cfg_i.bg;
      out_last_q  <= rest == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mask_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_mask_q  <= cur_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = gcr_pkg::OUT_DATA_BITS'({out_color_q, out_y_q, out_x_q});

  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> cur_mask_q != '0)
    else $error("loaded glyph word carries no writes");

endmodule

>>> rtl/glyph_column_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_column_rasterizer_top
// Turns glyph column words into pixel writes, with clip registers on APB.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-------------------------------
//  s_axis   | in        | tvalid / tready  | glyph word, tuser = first_byte
//  m_axis   | out       | tvalid / tready  | pixel write, tlast = last_of_byte
//  apb      | in        | psel / penable   | 3 registers at 0x0, 0x4, 0x8
//
// Front takes one glyph word per cycle unless the queue is full; back issues
// one pixel write per cycle unless m_axis stalls; a word yields 0 to 8 writes.
// A four-entry queue separates front and back; s_axis_tready drops when full.
// Reset restores the register defaults and ends any character; no clear pass.
// ----------------------------------------------------------------------------
module glyph_column_rasterizer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: start_x, start_y, glyph_height, overwrite, fg_color, glyph_byte
  input  logic [gcr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // tuser: first_byte
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_color
  output logic [gcr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gcr_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [gcr_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [gcr_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  gcr_pkg::gcr_cfg_t    cfg_q;
  gcr_pkg::gcr_entry_t  push_entry, pop_entry;
  gcr_pkg::reg_idx_e    reg_idx;
  logic                 push, pop, fifo_full, fifo_valid, cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = gcr_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= gcr_pkg::WIDTH_RST;
      cfg_q.height <= gcr_pkg::HEIGHT_RST;
      cfg_q.bg     <= gcr_pkg::BG_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        gcr_pkg::REG_SCREEN_WIDTH:  cfg_q.width  <= pwdata[gcr_pkg::DIM_BITS-1:0];
        gcr_pkg::REG_SCREEN_HEIGHT: cfg_q.height <= pwdata[gcr_pkg::DIM_BITS-1:0];
        gcr_pkg::REG_BG_COLOR:      cfg_q.bg     <= pwdata[gcr_pkg::COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gcr_pkg::REG_SCREEN_WIDTH:  prdata = gcr_pkg::APB_DATA_BITS'(cfg_q.width);
      gcr_pkg::REG_SCREEN_HEIGHT: prdata = gcr_pkg::APB_DATA_BITS'(cfg_q.height);
      gcr_pkg::REG_BG_COLOR:      prdata = gcr_pkg::APB_DATA_BITS'(cfg_q.bg);
      default:                    prdata = '0;
    endcase
  end

  gcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_first_i  (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .cfg_i       (cfg_q),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  gcr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .entry_o (pop_entry)
  );

  gcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_entry_i (pop_entry),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

>>> tb/sv/glyph_column_rasterizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_column_rasterizer_top_test
// Self-checking bench for the glyph column rasterizer. Glyph words go in on
// the slave stream with random valid gaps; pixel writes come out on the master
// stream with random backpressure. A behavioral model in the bench tracks each
// character (position, height, mode, color, clip limits) and predicts every pixel
// write. Each write is compared field by field with the oldest prediction.
// The bench also writes and reads back the clip and background registers
// over APB. Phases: register reset values, directed special cases, clip
// extremes, coordinate wrap, then random characters mixed with noise words.
// ----------------------------------------------------------------------------
module glyph_column_rasterizer_top_test;

  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_LINES    = 100;

  localparam int CB = gcr_pkg::COORD_BITS;
  localparam int KB = gcr_pkg::COLOR_BITS;
  localparam int HB = gcr_pkg::HEIGHT_BITS;
  localparam int GB = gcr_pkg::GLYPH_BITS;
  localparam int DB = gcr_pkg::DIM_BITS;
  localparam int AB = gcr_pkg::APB_DATA_BITS;

  typedef struct packed {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic [KB-1:0] color;
    logic          last;
  } pixel_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  // tdata: start_x, start_y, glyph_height, overwrite, fg_color, glyph_byte
  logic [gcr_pkg::IN_DATA_BITS-1:0]    s_axis_tdata;
  // tuser: first_byte
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  // tdata: pixel_x, pixel_y, pixel_color
  logic [gcr_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;
  logic                                m_axis_tlast;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [gcr_pkg::APB_ADDR_BITS-1:0]   paddr;
  logic [AB-1:0]                       pwdata;
  logic [AB-1:0]                       prdata;
  logic                                pready;

  // register shadows
  logic [DB-1:0]  scr_w;
  logic [DB-1:0]  scr_h;
  logic [KB-1:0]  bg_color;

  // character state of the model
  logic [CB-1:0]  cur_col;
  logic [CB-1:0]  cur_row;
  logic [CB-1:0]  cur_top;
  logic [HB-1:0]  cur_h;
  logic           cur_ovw;
  logic [KB-1:0]  cur_fg;
  logic           char_on;

  pixel_t pending_pixels[$];
  pixel_t want_px;
  bit     stall_en;
  int     mismatch_count;
  int     words_sent;
  int     pixels_checked;

  glyph_column_rasterizer_top uut (.*);

  always #10 clk_i = ~clk_i;

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_LINES) $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic void rasterize_word(input logic first,
                                         input logic [CB-1:0] x,
                                         input logic [CB-1:0] y,
                                         input logic [HB-1:0] h,
                                         input logic ovw,
                                         input logic [KB-1:0] fg,
                                         input logic [GB-1:0] glyph);
    pixel_t        writes[$];
    pixel_t        w;
    int            nxt;
    logic [CB-1:0] span;
    if (first) begin
      cur_col = x;
      cur_row = y;
      cur_top = y;
      cur_h   = h;
      cur_ovw = ovw;
      cur_fg  = fg;
      char_on = (h == gcr_pkg::FONT_H12) || (h == gcr_pkg::FONT_H16) ||
                (h == gcr_pkg::FONT_H24) || (h == gcr_pkg::FONT_H32);
    end
    if (!char_on) return;
    for (int b = GB - 1; b >= 0; b--) begin
      if (glyph[b] || cur_ovw) begin
        w.px    = cur_col;
        w.py    = cur_row;
        w.color = glyph[b] ? cur_fg : bg_color;
        w.last  = 1'b0;
        writes.push_back(w);
      end
      nxt = int'(cur_row) + 1;
      if (nxt >= int'(scr_h)) begin
        char_on = 1'b0;
        break;
      end
      cur_row = CB'(nxt);
      span = cur_row - cur_top;
      if (span == CB'(cur_h)) begin
        cur_row = cur_top;
        nxt = int'(cur_col) + 1;
        if (nxt >= int'(scr_w)) begin
          char_on = 1'b0;
          break;
        end
        cur_col = CB'(nxt);
        break;
      end
    end
    if (writes.size() > 0) writes[writes.size() - 1].last = 1'b1;
    foreach (writes[i]) pending_pixels.push_back(writes[i]);
  endfunction

  task automatic send_word(input logic first,
                           input logic [CB-1:0] x,
                           input logic [CB-1:0] y,
                           input logic [HB-1:0] h,
                           input logic ovw,
                           input logic [KB-1:0] fg,
                           input logic [GB-1:0] glyph);
    logic [gcr_pkg::IN_DATA_BITS-1:0] word;
    word = '0;
    word[gcr_pkg::IN_X_LSB +: CB]     = x;
    word[gcr_pkg::IN_Y_LSB +: CB]     = y;
    word[gcr_pkg::IN_H_LSB +: HB]     = h;
    word[gcr_pkg::IN_MODE_LSB]        = ovw;
    word[gcr_pkg::IN_FG_LSB +: KB]    = fg;
    word[gcr_pkg::IN_GLYPH_LSB +: GB] = glyph;
    @(negedge clk_i);
    while (stall_en && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rasterize_word(first, x, y, h, ovw, fg, glyph);
    words_sent++;
  endtask

  // first word starts the character, the rest carry junk in ignored fields
  task automatic send_char(input int x, input int y, input int h, input int ovw,
                           input int fg, input int nwords);
    logic [GB-1:0] glyph;
    for (int i = 0; i < nwords; i++) begin
      case ($urandom_range(0, 7))
        0:       glyph = '0;
        1:       glyph = '1;
        default: glyph = GB'($urandom);
      endcase
      if (i == 0) begin
        send_word(1'b1, CB'(x), CB'(y), HB'(h), ovw[0], KB'(fg), glyph);
      end else begin
        send_word(1'b0, CB'($urandom), CB'($urandom), HB'($urandom), 1'($urandom),
                  KB'($urandom), glyph);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic read_reg(input gcr_pkg::reg_idx_e idx);
    logic [AB-1:0] want;
    case (idx)
      gcr_pkg::REG_SCREEN_WIDTH:  want = AB'(scr_w);
      gcr_pkg::REG_SCREEN_HEIGHT: want = AB'(scr_h);
      default:                    want = AB'(bg_color);
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want)
      report($sformatf("register %s read 0x%0h, want 0x%0h", idx.name(), prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input gcr_pkg::reg_idx_e idx, input logic [AB-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      gcr_pkg::REG_SCREEN_WIDTH:  scr_w = val[DB-1:0];
      gcr_pkg::REG_SCREEN_HEIGHT: scr_h = val[DB-1:0];
      default:                    bg_color = val[KB-1:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    read_reg(idx);
  endtask

  task automatic set_screen(input int w, input int h, input int bg);
    wait_drained();
    write_reg(gcr_pkg::REG_SCREEN_WIDTH, w);
    write_reg(gcr_pkg::REG_SCREEN_HEIGHT, h);
    write_reg(gcr_pkg::REG_BG_COLOR, bg);
  endtask

  task automatic test_reset_values();
    read_reg(gcr_pkg::REG_SCREEN_WIDTH);
    read_reg(gcr_pkg::REG_SCREEN_HEIGHT);
    read_reg(gcr_pkg::REG_BG_COLOR);
  endtask

  task automatic test_directed();
    // byte with no character active
    send_word(1'b0, 0, 0, gcr_pkg::FONT_H12, 1'b1, 16'h0000, 8'hFF);
    // 12-row transparent character: full byte, empty tail, partial tail
    send_word(1'b1, 0, 0, gcr_pkg::FONT_H12, 1'b0, 16'h0000, 8'hFF);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'h00);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'hA5);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'hF0);
    // overwrite mode
    send_word(1'b1, 100, 200, gcr_pkg::FONT_H16, 1'b1, 16'hFFFF, 8'h5A);
    send_word(1'b0, 2047, 2047, 63, 1'b0, 16'hFFFF, 8'h00);
    send_word(1'b1, 300, 100, gcr_pkg::FONT_H24, 1'b1, 16'h1234, 8'h81);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'h7E);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'h3C);
    send_word(1'b1, 400, 50, gcr_pkg::FONT_H32, 1'b0, 16'hFFFF, 8'h01);
    send_word(1'b0, 0, 0, 0, 1'b1, 0, 8'h80);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'hFF);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'h00);
    // unsupported heights draw nothing
    send_word(1'b1, 10, 10, 0, 1'b1, 16'hFFFF, 8'hFF);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'hFF);
    send_word(1'b1, 10, 10, 63, 1'b1, 16'hFFFF, 8'hFF);
    send_word(1'b1, 10, 10, 13, 1'b1, 16'hFFFF, 8'hFF);
    // bottom edge, start outside the screen, right edge
    send_word(1'b1, 5, 479, gcr_pkg::FONT_H12, 1'b1, 16'h00FF, 8'hFF);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'hFF);
    send_word(1'b1, 2047, 2047, gcr_pkg::FONT_H16, 1'b0, 16'hFF00, 8'h80);
    send_word(1'b1, 799, 0, gcr_pkg::FONT_H12, 1'b0, 16'h0F0F, 8'hFF);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'hFF);
    send_word(1'b0, 0, 0, 0, 1'b0, 0, 8'h0F);
  endtask

  task automatic test_clip_extremes();
    set_screen(1, 1, 16'h0000);
    send_char(0, 0, gcr_pkg::FONT_H12, 1, 16'hFFFF, 3);
    send_char(0, 0, gcr_pkg::FONT_H32, 0, 16'hA5A5, 2);
    set_screen(2048, 2048, 16'hFFFF);
    send_char(2047, 2040, gcr_pkg::FONT_H16, 1, 16'h0000, 3);
    send_char(2046, 0, gcr_pkg::FONT_H12, 0, 16'h5555, 6);
    send_char(0, 2047, gcr_pkg::FONT_H24, 1, 16'hAAAA, 2);
  endtask

  task automatic test_coord_wrap();
    set_screen(4095, 4095, 16'h8001);
    send_char(2047, 2044, gcr_pkg::FONT_H12, 1, 16'h7FFE, 6);
    send_char(2046, 2040, gcr_pkg::FONT_H32, 0, 16'hC3C3, 9);
  endtask

  task automatic test_random_chars();
    int sent;
    int h;
    int bpc;
    int n;
    int x;
    int y;
    for (int phase = 0; phase < 4; phase++) begin
      set_screen($urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 2048),
                 $urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 2048),
                 $urandom_range(0, 65535));
      stall_en = (phase != 1);
      sent = 0;
      while (sent < 85) begin
        case ($urandom_range(0, 9))
          0: begin
            send_word(1'($urandom), CB'($urandom), CB'($urandom), HB'($urandom),
                      1'($urandom), KB'($urandom), GB'($urandom));
            sent++;
          end
          1: begin
            h = $urandom_range(0, 63);
            if (h == 12 || h == 16 || h == 24 || h == 32) h++;
            send_char($urandom, $urandom, h, $urandom, $urandom, 2);
            sent += 2;
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       h = gcr_pkg::FONT_H12;
              1:       h = gcr_pkg::FONT_H16;
              2:       h = gcr_pkg::FONT_H24;
              default: h = gcr_pkg::FONT_H32;
            endcase
            bpc = (h + 7) / 8;
            n = bpc * $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, bpc);
            x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                             : $urandom_range(0, int'(scr_w) - 1);
            y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                             : $urandom_range(0, int'(scr_h) - 1);
            send_char(x, y, h, $urandom_range(0, 1), $urandom_range(0, 65535), n);
            sent += n;
          end
        endcase
      end
    end
    stall_en = 1'b1;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !stall_en || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel write x=%0d y=%0d with none expected",
                         m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB]));
      end else begin
        want_px = pending_pixels.pop_front();
        if (m_axis_tdata[CB-1:0] !== want_px.px)
          report($sformatf("pixel_x %0d, want %0d", m_axis_tdata[CB-1:0], want_px.px));
        if (m_axis_tdata[2*CB-1:CB] !== want_px.py)
          report($sformatf("pixel_y %0d, want %0d",
                           m_axis_tdata[2*CB-1:CB], want_px.py));
        if (m_axis_tdata[2*CB +: KB] !== want_px.color)
          report($sformatf("pixel_color 0x%0h, want 0x%0h",
                           m_axis_tdata[2*CB +: KB], want_px.color));
        if (m_axis_tlast !== want_px.last)
          report($sformatf("last_of_byte %b, want %b", m_axis_tlast, want_px.last));
        pixels_checked++;
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    scr_w          = gcr_pkg::WIDTH_RST;
    scr_h          = gcr_pkg::HEIGHT_RST;
    bg_color       = gcr_pkg::BG_RST;
    cur_col        = '0;
    cur_row        = '0;
    cur_top        = '0;
    cur_h          = '0;
    cur_ovw        = 1'b0;
    cur_fg         = '0;
    char_on        = 1'b0;
    stall_en       = 1'b1;
    mismatch_count = 0;
    words_sent     = 0;
    pixels_checked = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_directed();
    test_clip_extremes();
    test_coord_wrap();
    test_random_chars();

    wait_drained();
    $display("%0d glyph words sent, %0d pixel writes checked", words_sent, pixels_checked);
    $display("covered: directed cases, clip extremes, coordinate wrap, random characters");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
